// ===== hdl/rmth_pkg.sv =====
// Shared types, constants and helpers for the running median block.
`timescale 1ns / 1ps

package rmth_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int MEDIAN_W     = 33;
  localparam int COUNT_W      = 11;
  localparam int CAPACITY_DEF = 1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    sample_t    x;
  } chain_ctrl_t;

  function automatic logic nearer(input logic is_max, input sample_t a, input sample_t b);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ===== hdl/rmth_cell.sv =====
// One cell of a sorted chain: holds one value, shifts on push or pop.
`timescale 1ns / 1ps

module rmth_cell import rmth_pkg::*; #(
  parameter bit IS_MAX = 1'b1
) (
  input  logic       clk,
  input  logic [1:0] op,
  input  sample_t    x,
  input  logic       occupied,
  input  sample_t    prev_value,
  input  logic       prev_ins,
  input  sample_t    next_value,
  output sample_t    value,
  output logic       ins
);

  always_comb begin
    ins = !occupied || nearer(IS_MAX, x, value);
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_PUSH: begin
        if (ins) begin
          value <= prev_ins ? prev_value : x;
        end
      end
      OP_POP: begin
        value <= next_value;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

// ===== hdl/rmth_chain.sv =====
// Row of cells kept in sorted order with the head at cell zero, plus its fill count.
`timescale 1ns / 1ps

module rmth_chain import rmth_pkg::*; #(
  parameter int DEPTH  = (CAPACITY_DEF + 1) / 2,
  parameter bit IS_MAX = 1'b1,
  parameter int SIZE_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  chain_ctrl_t       ctrl,
  output sample_t           head,
  output logic [SIZE_W-1:0] size
);

  sample_t vals     [DEPTH];
  logic    ins_v    [DEPTH];
  sample_t prev_val [DEPTH];
  logic    prev_ins [DEPTH];
  sample_t next_val [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign prev_val[i] = ctrl.x;
        assign prev_ins[i] = 1'b0;
      end else begin : g_rest
        assign prev_val[i] = vals[i-1];
        assign prev_ins[i] = ins_v[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_val[i] = vals[i];
      end else begin : g_mid
        assign next_val[i] = vals[i+1];
      end

      rmth_cell #(.IS_MAX(IS_MAX)) u_cell (
        .clk       (clk),
        .op        (ctrl.op),
        .x         (ctrl.x),
        .occupied  (SIZE_W'(i) < size),
        .prev_value(prev_val[i]),
        .prev_ins  (prev_ins[i]),
        .next_value(next_val[i]),
        .value     (vals[i]),
        .ins       (ins_v[i])
      );
    end
  endgenerate

  assign head = vals[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
    end else begin
      case (ctrl.op)
        OP_PUSH: size <= size + SIZE_W'(1);
        OP_POP:  size <= size - SIZE_W'(1);
        default: size <= size;
      endcase
    end
  end

endmodule

// ===== hdl/running_median_two_heap.sv =====
// Top level: running median over a lower and an upper chain of cells.
//
//  channel | direction | words                                  | handshake
//  sample  | in        | sample                                 | sample_valid / sample_ready
//  result  | out       | median_doubled, sample_count, dropped  | result_valid / result_ready
//
// An accepted word passes through states OP1 and DONE to the result load, with OP2
// between them when a root moves between the chains.
// Each chain step is one parallel compare-and-shift across all cells.
// Reset clears the fill counts and the sequencer; cell contents need none.
// A held result stalls only the result load; the next sample waits for idle,
// in the cycle after the load.
`timescale 1ns / 1ps

module running_median_two_heap import rmth_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [MEDIAN_W-1:0] median_doubled,
  output logic        [COUNT_W-1:0]  sample_count,
  output logic                       dropped
);

  localparam int DEPTH  = (CAPACITY + 1) / 2;
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = SIZE_W + 1;
  localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OP1  = 2'd1;
  localparam logic [1:0] ST_OP2  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  sample_t           s_reg;
  logic              drop_reg;
  logic              op2_upper;
  logic              op2_upper_next;
  chain_ctrl_t       lctrl;
  chain_ctrl_t       uctrl;
  sample_t           lhead;
  sample_t           uhead;
  logic [SIZE_W-1:0] lsize;
  logic [SIZE_W-1:0] usize;
  logic [CNT_W-1:0]  total;
  logic [EXT_W-1:0]  count_ext;
  logic              full;
  logic              to_lower;
  logic              load_out;
  logic signed [MEDIAN_W-1:0] med;

  rmth_chain #(.DEPTH(DEPTH), .IS_MAX(1'b1), .SIZE_W(SIZE_W)) u_lower (
    .clk (clk),
    .rst (rst),
    .ctrl(lctrl),
    .head(lhead),
    .size(lsize)
  );

  rmth_chain #(.DEPTH(DEPTH), .IS_MAX(1'b0), .SIZE_W(SIZE_W)) u_upper (
    .clk (clk),
    .rst (rst),
    .ctrl(uctrl),
    .head(uhead),
    .size(usize)
  );

  assign total     = CNT_W'(lsize) + CNT_W'(usize);
  assign count_ext = EXT_W'(total);
  assign full      = total >= CNT_W'(CAPACITY);
  assign to_lower  = (lsize == '0) || (lhead > s_reg);
  assign sample_ready = (state == ST_IDLE);
  assign load_out  = (state == ST_DONE) && (!result_valid || result_ready);

  always_comb begin
    if (lsize == '0 && usize == '0) begin
      med = '0;
    end else if (lsize == usize) begin
      med = MEDIAN_W'(lhead) + MEDIAN_W'(uhead);
    end else if (lsize > usize) begin
      med = {lhead, 1'b0};
    end else begin
      med = {uhead, 1'b0};
    end
  end

  always_comb begin
    state_next     = state;
    op2_upper_next = op2_upper;
    lctrl.op       = OP_HOLD;
    lctrl.x        = s_reg;
    uctrl.op       = OP_HOLD;
    uctrl.x        = s_reg;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_OP1;
        end
      end
      ST_OP1: begin
        state_next = ST_DONE;
        if (!full) begin
          if (to_lower) begin
            if (lsize > usize) begin
              lctrl.op       = OP_POP;
              uctrl.op       = OP_PUSH;
              uctrl.x        = lhead;
              op2_upper_next = 1'b0;
              state_next     = ST_OP2;
            end else begin
              lctrl.op = OP_PUSH;
            end
          end else if (usize > lsize) begin
            if (s_reg > uhead) begin
              uctrl.op       = OP_POP;
              lctrl.op       = OP_PUSH;
              lctrl.x        = uhead;
              op2_upper_next = 1'b1;
              state_next     = ST_OP2;
            end else begin
              lctrl.op = OP_PUSH;
            end
          end else begin
            uctrl.op = OP_PUSH;
          end
        end
      end
      ST_OP2: begin
        if (op2_upper) begin
          uctrl.op = OP_PUSH;
        end else begin
          lctrl.op = OP_PUSH;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op2_upper <= op2_upper_next;
    if (sample_ready && sample_valid) begin
      s_reg <= sample;
    end
    if (state == ST_OP1) begin
      drop_reg <= full;
    end
    if (load_out) begin
      median_doubled <= med;
      sample_count   <= count_ext[COUNT_W-1:0];
      dropped        <= drop_reg;
    end
  end

  a_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      (CNT_W'(lsize) <= CNT_W'(usize) + CNT_W'(1)) &&
      (CNT_W'(usize) <= CNT_W'(lsize) + CNT_W'(1)))
    else $error("chain sizes differ by more than one");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CAPACITY))
    else $error("store holds more than its capacity");

  a_partition: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && lsize != '0 && usize != '0) |-> (lhead <= uhead))
    else $error("lower root above upper root");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && dropped) |-> (total == CNT_W'(CAPACITY)))
    else $error("word dropped while store not full");

  a_op2_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OP2) |-> ($past(state) == ST_OP1))
    else $error("second chain step without a first");

endmodule

// ===== tb/running_median_two_heap_tb.sv =====
// Self-checking testbench for the running median block with a two-heap scoreboard model.
`timescale 1ns / 1ps

module running_median_two_heap_tb;
  import rmth_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int HEAP_DEPTH  = (CAPACITY + 1) / 2;
  localparam int LOWER       = 0;
  localparam int UPPER       = 1;
  localparam int RANDOM_WORDS = 1950;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic signed [MEDIAN_W-1:0] median;
    logic        [COUNT_W-1:0]  count;
    logic                       dropped;
  } median_word_t;

  class median_scoreboard;
    sample_t      heap [2][HEAP_DEPTH];
    int           fill [2];
    median_word_t expected_words [$];
    int           errors;

    function bit outranks(int side, sample_t a, sample_t b);
      return (side == LOWER) ? (a > b) : (a < b);
    endfunction

    function void push(int side, sample_t v);
      int i;
      int p;
      i = fill[side];
      if (i >= HEAP_DEPTH) return;
      fill[side] = i + 1;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (outranks(side, v, heap[side][p])) begin
          heap[side][i] = heap[side][p];
          i = p;
        end else begin
          break;
        end
      end
      heap[side][i] = v;
    endfunction

    function void replace_root(int side, sample_t v);
      int i;
      int l;
      int c;
      i = 0;
      while (1) begin
        l = 2 * i + 1;
        if (l >= fill[side]) break;
        c = l;
        if (l + 1 < fill[side] && outranks(side, heap[side][l+1], heap[side][l])) c = l + 1;
        if (outranks(side, heap[side][c], v)) begin
          heap[side][i] = heap[side][c];
          i = c;
        end else begin
          break;
        end
      end
      heap[side][i] = v;
    endfunction

    function void insert(sample_t s);
      sample_t moved;
      if (fill[LOWER] == 0 || heap[LOWER][0] > s) begin
        if (fill[LOWER] > fill[UPPER]) begin
          moved = heap[LOWER][0];
          replace_root(LOWER, s);
          push(UPPER, moved);
        end else begin
          push(LOWER, s);
        end
      end else begin
        if (fill[UPPER] > fill[LOWER]) begin
          if (s > heap[UPPER][0]) begin
            moved = heap[UPPER][0];
            replace_root(UPPER, s);
          end else begin
            moved = s;
          end
          push(LOWER, moved);
        end else begin
          push(UPPER, s);
        end
      end
    endfunction

    function logic signed [MEDIAN_W-1:0] median_doubled_now();
      logic signed [MEDIAN_W-1:0] lo;
      logic signed [MEDIAN_W-1:0] hi;
      if (fill[LOWER] == 0 && fill[UPPER] == 0) return '0;
      lo = heap[LOWER][0];
      hi = heap[UPPER][0];
      if (fill[LOWER] == fill[UPPER]) return lo + hi;
      if (fill[LOWER] > fill[UPPER]) return lo + lo;
      return hi + hi;
    endfunction

    function void note_sample(sample_t s);
      median_word_t w;
      w.dropped = (fill[LOWER] + fill[UPPER] >= CAPACITY);
      if (!w.dropped) insert(s);
      w.median = median_doubled_now();
      w.count  = COUNT_W'(fill[LOWER] + fill[UPPER]);
      expected_words.push_back(w);
    endfunction

    function void check_result(logic signed [MEDIAN_W-1:0] md, logic [COUNT_W-1:0] cnt,
                               logic drp);
      median_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: median_doubled %0d", md);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (md !== w.median) begin
        $error("median_doubled: expected %0d, actual %0d", w.median, md);
        errors++;
      end
      if (cnt !== w.count) begin
        $error("sample_count: expected %0d, actual %0d", w.count, cnt);
        errors++;
      end
      if (drp !== w.dropped) begin
        $error("dropped: expected %0d, actual %0d", w.dropped, drp);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic        [COUNT_W-1:0]  sample_count;
  logic                       dropped;

  median_scoreboard sb;
  bit               idle_on = 1'b1;
  int               hold_request = 0;
  int               cycle_count = 0;
  sample_t          recent [8];

  running_median_two_heap #(.CAPACITY(CAPACITY)) dut (
    .clk, .rst, .sample_valid, .sample_ready, .sample,
    .result_valid, .result_ready, .median_doubled, .sample_count, .dropped
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return sample_t'($urandom);
    if (r < 65) return sample_t'($signed($urandom_range(0, 200)) - 100);
    if (r < 75) return $urandom_range(0, 1) ? sample_t'(32'sh7FFF_FFFF - $urandom_range(0, 2))
                                          : sample_t'(32'sh8000_0000 + $urandom_range(0, 2));
    if (r < 90) return recent[$urandom_range(0, 7)];
    return sample_t'({$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)});
  endfunction

  task automatic send_sample(sample_t v);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(v);
    recent[$urandom_range(0, 7)] = v;
  endtask

  initial begin
    int g;
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        sb.check_result(median_doubled, sample_count, dropped);
      if (!hold_taken && hold_request > 0) begin
        hold_left  = hold_request;
        hold_taken = 1'b1;
      end
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (idle_on) begin
        g = pick_gap();
        if (g > 0) begin
          hold_left = g - 1;
          result_ready <= 1'b0;
        end else begin
          result_ready <= 1'b1;
        end
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    sample_t directed [24];
    directed = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, -1, 1,
      5, 5, 5, 100, 90, 80, 70, 200, 300, 400, 250, 3, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    sb = new;
    foreach (recent[i]) recent[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b0;
    foreach (directed[i]) send_sample(directed[i]);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      idle_on = ((k / 150) % 3) != 1;
      if (k == 300) hold_request = LONG_HOLD;
      send_sample(pick_sample());
    end
    sample_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rmth_pkg.sv
hdl/rmth_cell.sv
hdl/rmth_chain.sv
hdl/running_median_two_heap.sv
tb/running_median_two_heap_tb.sv
